/* rtl/core/cmfs_pkg.sv */
// shared widths, types and face codes for the cube map face select core
package cmfs_pkg;

  // component, fraction, coordinate and face code widths
  localparam int COMP_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = FRAC_BITS + 1;
  localparam int FACE_W    = 3;

  // fraction bits of the quotient are spread over this many register stages
  localparam int DIV_STAGES      = 3;
  localparam int STEPS_PER_STAGE = (FRAC_BITS - 1 + DIV_STAGES - 1) / DIV_STAGES;

  // stream data widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((3 * COMP_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((FACE_W + 2 * COORD_W + 7) / 8) * 8;

  // face codes in test order
  typedef enum logic [FACE_W-1:0] {
    FACE_NEG_X,
    FACE_POS_X,
    FACE_NEG_Y,
    FACE_POS_Y,
    FACE_NEG_Z,
    FACE_POS_Z
  } cmfs_face_t;

  // input direction
  typedef struct packed {
    logic [COMP_BITS-1:0] z;
    logic [COMP_BITS-1:0] y;
    logic [COMP_BITS-1:0] x;
  } cmfs_dir_t;

  // face select stage output: major magnitude and the two dividends
  typedef struct packed {
    cmfs_face_t           face;
    logic                 degen;
    logic [COMP_BITS-1:0] mag;
    logic [COMP_BITS:0]   num_u;
    logic [COMP_BITS:0]   num_v;
  } cmfs_sel_t;

  // divider stage state for both lanes
  typedef struct packed {
    cmfs_face_t           face;
    logic                 degen;
    logic [COMP_BITS-1:0] mag;
    logic [COMP_BITS-1:0] rem_u;
    logic [COMP_BITS-1:0] rem_v;
    logic [COORD_W-1:0]   quo_u;
    logic [COORD_W-1:0]   quo_v;
  } cmfs_div_t;

  // finished result
  typedef struct packed {
    cmfs_face_t         face;
    logic               degen;
    logic [COORD_W-1:0] coord_u;
    logic [COORD_W-1:0] coord_v;
  } cmfs_res_t;

endpackage

/* rtl/core/cmfs_select.sv */
// major axis face select stage, forms magnitude and face coordinate dividends
module cmfs_select (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cmfs_pkg::cmfs_dir_t dir,
  output logic              out_valid,
  input  logic              out_ready,
  output cmfs_pkg::cmfs_sel_t sel
);
  import cmfs_pkg::*;

  logic                 valid_r;
  cmfs_sel_t            sel_r;
  cmfs_sel_t            sel_nxt;
  logic [COMP_BITS-1:0] ax, ay, az;
  logic [COMP_BITS:0]   sx, sy, sz;
  logic [COMP_BITS:0]   s_sel, t_sel;
  logic [COMP_BITS-1:0] m_sel;
  logic                 xmaj, ymaj, zmaj, xpos, ypos, zpos, degen;

  // two's complement magnitude, most negative value fits unsigned
  function automatic logic [COMP_BITS-1:0] mag_of(input logic [COMP_BITS-1:0] v);
    mag_of = v[COMP_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // negate a sign extended component
  function automatic logic [COMP_BITS:0] neg_of(input logic [COMP_BITS:0] v);
    neg_of = ~v + 1'b1;
  endfunction

  // magnitudes and axis tests
  always_comb begin
    ax    = mag_of(dir.x);
    ay    = mag_of(dir.y);
    az    = mag_of(dir.z);
    sx    = {dir.x[COMP_BITS-1], dir.x};
    sy    = {dir.y[COMP_BITS-1], dir.y};
    sz    = {dir.z[COMP_BITS-1], dir.z};
    xmaj  = (ax >= ay) && (ax >= az);
    ymaj  = (ay >= ax) && (ay >= az);
    zmaj  = (az >= ax) && (az >= ay);
    xpos  = !dir.x[COMP_BITS-1] && (dir.x != '0);
    ypos  = !dir.y[COMP_BITS-1] && (dir.y != '0);
    zpos  = !dir.z[COMP_BITS-1] && (dir.z != '0);
    degen = (dir.x == '0) && (dir.y == '0) && (dir.z == '0);
  end

  // face pick in test order, then s and t per face convention
  always_comb begin
    sel_nxt = '0;
    if (!xpos && xmaj) begin
      sel_nxt.face = FACE_NEG_X; m_sel = ax; s_sel = sz;         t_sel = sy;
    end else if (xpos && xmaj) begin
      sel_nxt.face = FACE_POS_X; m_sel = ax; s_sel = neg_of(sz); t_sel = sy;
    end else if (!ypos && ymaj) begin
      sel_nxt.face = FACE_NEG_Y; m_sel = ay; s_sel = sx;         t_sel = sz;
    end else if (ypos && ymaj) begin
      sel_nxt.face = FACE_POS_Y; m_sel = ay; s_sel = sx;         t_sel = neg_of(sz);
    end else if (!zpos && zmaj) begin
      sel_nxt.face = FACE_NEG_Z; m_sel = az; s_sel = neg_of(sx); t_sel = sy;
    end else begin
      sel_nxt.face = FACE_POS_Z; m_sel = az; s_sel = sx;         t_sel = sy;
    end
    if (degen) begin
      sel_nxt.face = FACE_NEG_X;
    end
    sel_nxt.degen = degen;
    sel_nxt.mag   = m_sel;
    // s + m lies in 0 .. 2m
    sel_nxt.num_u = s_sel + {1'b0, m_sel};
    sel_nxt.num_v = t_sel + {1'b0, m_sel};
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign sel       = sel_r;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      sel_r <= sel_nxt;
    end
  end

endmodule

/* rtl/core/cmfs_divider.sv */
// pipelined restoring divider for both face coordinates plus output stage
module cmfs_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cmfs_pkg::cmfs_sel_t sel,
  output logic                out_valid,
  input  logic                out_ready,
  output cmfs_pkg::cmfs_res_t res
);
  import cmfs_pkg::*;

  localparam logic [COORD_W-1:0] HALF = COORD_W'(1) << (FRAC_BITS - 1);

  // stage 0 is the integer step, stages 1..DIV_STAGES the fraction steps
  logic      st_valid_r [0:DIV_STAGES];
  cmfs_div_t st_r       [0:DIV_STAGES];
  cmfs_div_t st_nxt     [0:DIV_STAGES];
  logic      st_ready   [0:DIV_STAGES];
  logic      res_valid_r;
  cmfs_res_t res_r;
  cmfs_res_t res_nxt;
  logic      res_ready;

  // integer part of one lane: quotient 0, 1 or 2 and the remainder
  function automatic logic [COMP_BITS+1:0] int_step(input logic [COMP_BITS:0]   num,
                                                    input logic [COMP_BITS-1:0] m);
    logic [COMP_BITS:0] diff1;
    logic [COMP_BITS:0] diff2;
    diff1 = num - {1'b0, m};
    diff2 = num - {m, 1'b0};
    if (num >= {m, 1'b0}) begin
      int_step = {2'd2, diff2[COMP_BITS-1:0]};
    end else if (num >= {1'b0, m}) begin
      int_step = {2'd1, diff1[COMP_BITS-1:0]};
    end else begin
      int_step = {2'd0, num[COMP_BITS-1:0]};
    end
  endfunction

  // one quotient bit for both lanes, shifted in at the bottom
  function automatic cmfs_div_t frac_step(input cmfs_div_t d);
    cmfs_div_t          o;
    logic [COMP_BITS:0] ru, rv, mm;
    logic [COMP_BITS:0] du, dv;
    logic               bu, bv;
    o  = d;
    mm = {1'b0, d.mag};
    ru = {d.rem_u, 1'b0};
    rv = {d.rem_v, 1'b0};
    du = ru - mm;
    dv = rv - mm;
    bu = (ru >= mm);
    bv = (rv >= mm);
    o.rem_u = bu ? du[COMP_BITS-1:0] : ru[COMP_BITS-1:0];
    o.rem_v = bv ? dv[COMP_BITS-1:0] : rv[COMP_BITS-1:0];
    o.quo_u = {d.quo_u[COORD_W-2:0], bu};
    o.quo_v = {d.quo_v[COORD_W-2:0], bv};
    frac_step = o;
  endfunction

  // integer step from the select stage
  always_comb begin
    logic [COMP_BITS+1:0] iu;
    logic [COMP_BITS+1:0] iv;
    iu = int_step(sel.num_u, sel.mag);
    iv = int_step(sel.num_v, sel.mag);
    st_nxt[0].face  = sel.face;
    st_nxt[0].degen = sel.degen;
    st_nxt[0].mag   = sel.mag;
    st_nxt[0].rem_u = iu[COMP_BITS-1:0];
    st_nxt[0].rem_v = iv[COMP_BITS-1:0];
    st_nxt[0].quo_u = COORD_W'(iu[COMP_BITS+1:COMP_BITS]);
    st_nxt[0].quo_v = COORD_W'(iv[COMP_BITS+1:COMP_BITS]);
  end

  // fraction stages, a fixed group of quotient bits each
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_frac
    always_comb begin
      cmfs_div_t d;
      d = st_r[k-1];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if ((k - 1) * STEPS_PER_STAGE + j < FRAC_BITS - 1) begin
          d = frac_step(d);
        end
      end
      st_nxt[k] = d;
    end
  end

  // output formatting: zero vector override and v negation
  always_comb begin
    logic [COORD_W-1:0] qv;
    qv              = st_r[DIV_STAGES].degen ? HALF : st_r[DIV_STAGES].quo_v;
    res_nxt.face    = st_r[DIV_STAGES].face;
    res_nxt.degen   = st_r[DIV_STAGES].degen;
    res_nxt.coord_u = st_r[DIV_STAGES].degen ? HALF : st_r[DIV_STAGES].quo_u;
    res_nxt.coord_v = ~qv + 1'b1;
  end

  // backpressure: a stage takes data when empty or when it drains downstream
  assign res_ready = !res_valid_r || out_ready;
  always_comb begin
    st_ready[DIV_STAGES] = !st_valid_r[DIV_STAGES] || res_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      st_ready[k] = !st_valid_r[k] || st_ready[k+1];
    end
  end

  // stage 0 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r[0] <= 1'b0;
    end else if (st_ready[0]) begin
      st_valid_r[0] <= in_valid;
    end
    if (st_ready[0] && in_valid) begin
      st_r[0] <= st_nxt[0];
    end
  end

  // fraction stage registers
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_frac_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_valid_r[k] <= 1'b0;
      end else if (st_ready[k]) begin
        st_valid_r[k] <= st_valid_r[k-1];
      end
      if (st_ready[k] && st_valid_r[k-1]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_ready) begin
      res_valid_r <= st_valid_r[DIV_STAGES];
    end
    if (res_ready && st_valid_r[DIV_STAGES]) begin
      res_r <= res_nxt;
    end
  end

  assign in_ready  = st_ready[0];
  assign out_valid = res_valid_r;
  assign res       = res_r;

endmodule

/* rtl/core/cube_map_face_select_core.sv */
// cube map face select core: face pick and face coordinates for a direction stream
//
// channel | direction | tdata fields, low bit first            | tuser
// in_     | slave     | dir_x[15:0] dir_y[31:16] dir_z[47:32]     | -
// out_    | master    | face[2:0] coord_u[19:3] coord_v[36:20]    | degenerate
//
// one transfer per cycle on both sides while the output is not stalled; registers from
// input to output: face select, integer divide step, three fraction stages of five
// quotient bits per lane, output register
// reset clears only the stage valid bits; payload registers are not reset
// a stall on the output holds full stages and lets empty ones fill
module cube_map_face_select_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cmfs_pkg::IN_TDATA_W-1:0]  in_tdata,  // dir_x, dir_y, dir_z
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cmfs_pkg::OUT_TDATA_W-1:0] out_tdata, // face, coord_u, coord_v, pad
  output logic                             out_tuser  // degenerate
);
  import cmfs_pkg::*;

  cmfs_dir_t dir;
  cmfs_sel_t sel;
  logic      sel_valid;
  logic      sel_ready;
  cmfs_res_t res;

  // unpack input fields
  assign dir.x = in_tdata[COMP_BITS-1:0];
  assign dir.y = in_tdata[2*COMP_BITS-1:COMP_BITS];
  assign dir.z = in_tdata[3*COMP_BITS-1:2*COMP_BITS];

  cmfs_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .dir       (dir),
    .out_valid (sel_valid),
    .out_ready (sel_ready),
    .sel       (sel)
  );

  cmfs_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .sel       (sel),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  // pack output fields
  assign out_tdata = OUT_TDATA_W'({res.coord_v, res.coord_u, res.face});
  assign out_tuser = res.degen;

  // zero vector always reports face -X with coord_u at one half
  a_degen_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[FACE_W-1:0] == FACE_NEG_X) &&
      (out_tdata[FACE_W+COORD_W-1:FACE_W] == (COORD_W'(1) << (FRAC_BITS - 1))))
    else $error("degenerate result with wrong face or coordinate");

  // u never exceeds 1.0
  a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[FACE_W+COORD_W-1] |->
      (out_tdata[FACE_W+COORD_W-2:FACE_W] == '0))
    else $error("coord_u above one");

  // v is zero or negative
  a_v_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tdata[FACE_W+2*COORD_W-1:FACE_W+COORD_W] == '0) ||
      out_tdata[FACE_W+2*COORD_W-1])
    else $error("coord_v positive");

  // face code within the six faces
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[FACE_W-1:0] <= FACE_POS_Z))
    else $error("face code out of range");

endmodule

/* tb/tb.sv */
// self-checking testbench for the cube map face select core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmfs_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic {RX_ALWAYS, RX_STREAKS} rx_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // dir_x, dir_y, dir_z
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // face, coord_u, coord_v, pad
  logic                   out_tuser;  // degenerate

  cmfs_res_t face_expect_q[$];
  int        mismatch_count;
  int        results_seen;
  int        face_hits[6];
  int        zero_vectors;
  int        in_stall_cycles;
  longint    cycle_count;

  rx_mode_t  rx_mode;
  int        rx_hold_cycles;
  int        rx_streak;
  logic      rx_level;
  bit        tx_gaps;
  int        tx_burst_left;

  cube_map_face_select_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // face pick by major axis in test order, then floor-scaled face coordinates
  function automatic cmfs_res_t predict_face(input logic signed [COMP_BITS-1:0] x, y, z);
    longint    sx, sy, sz, ax, ay, az, s, t, m, uq, vq;
    logic      xmaj, ymaj;
    cmfs_res_t r;
    sx = x;
    sy = y;
    sz = z;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    xmaj = (ax >= ay) && (ax >= az);
    ymaj = (ay >= ax) && (ay >= az);
    if (sx <= 0 && xmaj) begin
      r.face = FACE_NEG_X; m = ax; s = sz;  t = sy;
    end else if (xmaj) begin
      r.face = FACE_POS_X; m = ax; s = -sz; t = sy;
    end else if (sy <= 0 && ymaj) begin
      r.face = FACE_NEG_Y; m = ay; s = sx;  t = sz;
    end else if (ymaj) begin
      r.face = FACE_POS_Y; m = ay; s = sx;  t = -sz;
    end else if (sz <= 0) begin
      r.face = FACE_NEG_Z; m = az; s = -sx; t = sy;
    end else begin
      r.face = FACE_POS_Z; m = az; s = sx;  t = sy;
    end
    // zero vector: no division, center of face -X
    if (m == 0) begin
      r.face  = FACE_NEG_X;
      r.degen = 1'b1;
      uq = longint'(1) << (FRAC_BITS - 1);
      vq = uq;
    end else begin
      r.degen = 1'b0;
      uq = ((s + m) << FRAC_BITS) / (2 * m);
      vq = ((t + m) << FRAC_BITS) / (2 * m);
    end
    r.coord_u = COORD_W'(uq);
    r.coord_v = COORD_W'(-vq);
    return r;
  endfunction

  // offer one direction and hold it until the transfer happens
  task automatic send_direction(input logic [COMP_BITS-1:0] x, y, z);
    in_tdata  <= {z, y, x};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    face_expect_q.push_back(predict_face(x, y, z));
    @(negedge clk);
  endtask

  // sender bursts with random gaps between them
  task automatic tx_pace();
    int gap;
    if (!tx_gaps) return;
    if (tx_burst_left > 0) begin
      tx_burst_left--;
      return;
    end
    tx_burst_left = $urandom_range(0, 15);
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // sender pauses until every expected result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (face_expect_q.size() != 0) @(negedge clk);
  endtask

  // component near a given magnitude: equal, negated, inside or zero
  function automatic int near_mag(input int a);
    case ($urandom_range(0, 3))
      0:       return a;
      1:       return -a;
      2:       return int'($urandom_range(0, 2 * a)) - a;
      default: return 0;
    endcase
  endfunction

  task automatic test_directed();
    rx_mode = RX_STREAKS;
    tx_gaps = 1'b1;
    send_direction(0, 0, 0);
    send_direction(-32768, 0, 0);
    send_direction(32767, 0, 0);
    send_direction(0, -32768, 0);
    send_direction(0, 32767, 0);
    send_direction(0, 0, -32768);
    send_direction(0, 0, 32767);
    send_direction(-32768, -32768, -32768);
    send_direction(32767, 32767, 32767);
    send_direction(-32768, 32767, -32768);
    // coordinates at both edges of the face
    send_direction(100, -100, 100);
    send_direction(100, 100, -100);
    send_direction(-7, 7, -7);
    send_direction(3, -3, 2);
    send_direction(0, 5, -5);
    send_direction(1, 0, 0);
    send_direction(-1, 0, 0);
    send_direction(0, 0, 1);
    send_direction(0, 0, -1);
    send_direction(2, -1, 1);
    send_direction(-32768, -32767, 32767);
    send_direction(1234, -32768, 32767);
    send_direction(0, -1, 1);
    send_direction(32767, -32768, 5);
  endtask

  task automatic test_random_full(input int count);
    rx_mode = RX_STREAKS;
    tx_gaps = 1'b1;
    repeat (count) begin
      send_direction(COMP_BITS'($urandom()), COMP_BITS'($urandom()),
                     COMP_BITS'($urandom()));
      tx_pace();
    end
  endtask

  // ties and sign combinations around one magnitude, small ones included
  task automatic test_ties(input int count);
    int a;
    rx_mode = RX_STREAKS;
    tx_gaps = 1'b1;
    repeat (count) begin
      a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(0, 32768);
      send_direction(COMP_BITS'(near_mag(a)), COMP_BITS'(near_mag(a)),
                     COMP_BITS'(near_mag(a)));
      tx_pace();
    end
  endtask

  task automatic test_full_rate(input int count);
    rx_mode = RX_ALWAYS;
    tx_gaps = 1'b0;
    repeat (count) send_direction(COMP_BITS'($urandom()), COMP_BITS'($urandom()),
                                  COMP_BITS'($urandom()));
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_backpressure(input int count);
    rx_mode = RX_ALWAYS;
    tx_gaps = 1'b0;
    @(posedge clk);
    rx_hold_cycles = 80;
    @(negedge clk);
    repeat (count) send_direction(COMP_BITS'($urandom()), COMP_BITS'($urandom()),
                                  COMP_BITS'($urandom()));
  endtask

  // receiver: long hold when asked, else ready or random stall streaks
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_mode == RX_ALWAYS) begin
        out_tready <= 1'b1;
      end else begin
        if (rx_streak == 0) begin
          rx_streak = $urandom_range(1, 10);
          rx_level  = ($urandom_range(0, 99) >= 35);
        end
        rx_streak--;
        out_tready <= rx_level;
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    cmfs_res_t want;
    logic [FACE_W-1:0]  got_face;
    logic [COORD_W-1:0] got_u, got_v;
    if (rst_n && in_tvalid && !in_tready) in_stall_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      got_face = out_tdata[FACE_W-1:0];
      got_u    = out_tdata[FACE_W +: COORD_W];
      got_v    = out_tdata[FACE_W+COORD_W +: COORD_W];
      results_seen++;
      if (face_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result transfer: face %0d u %h v %h degenerate %b",
                   got_face, got_u, got_v, out_tuser);
      end else begin
        want = face_expect_q.pop_front();
        if (got_face != want.face || got_u != want.coord_u || got_v != want.coord_v ||
            out_tuser != want.degen) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: face %0d/%0d u %h/%h v %h/%h degenerate %b/%b (exp/got)",
                     want.face, got_face, want.coord_u, got_u, want.coord_v, got_v,
                     want.degen, out_tuser);
        end
        if (want.face <= FACE_POS_Z) face_hits[want.face]++;
        if (want.degen) zero_vectors++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, face_expect_q.size());
      $display("cube_map_face_select_core test failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    rx_mode        = RX_ALWAYS;
    rx_hold_cycles = 0;
    rx_streak      = 0;
    rx_level       = 1'b1;
    tx_gaps        = 1'b0;
    tx_burst_left  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    wait_drained();
    test_random_full(480);
    wait_drained();
    test_ties(300);
    wait_drained();
    test_full_rate(120);
    wait_drained();
    test_backpressure(50);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (face_expect_q.size() != 0) mismatch_count++;

    $display("covered %0d results: -X %0d +X %0d -Y %0d +Y %0d -Z %0d +Z %0d, %0d zero vectors",
             results_seen, face_hits[0], face_hits[1], face_hits[2], face_hits[3],
             face_hits[4], face_hits[5], zero_vectors);
    $display("input stalled %0d cycles under output back-pressure, %0d mismatches",
             in_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("cube_map_face_select_core test passed");
    end else begin
      $display("cube_map_face_select_core test failed");
    end
    $finish;
  end

endmodule
